// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the spline record parser RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SRP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/srp_pkg.sv =====
// Shared types, codes and helpers for the spline record parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package srp_pkg;

   typedef enum logic [4:0] {
      PH_HDR1         = 5'd0,
      PH_HDR2         = 5'd1,
      PH_PRE_SLOPE    = 5'd2,
      PH_POST_SLOPE   = 5'd3,
      PH_PROTO_START  = 5'd4,
      PH_PROTO_END    = 5'd5,
      PH_PRE_LOOPS    = 5'd6,
      PH_POST_LOOPS   = 5'd7,
      PH_VALUE_OFFSET = 5'd8,
      PH_COUNT        = 5'd9,
      PH_K_FLAG       = 5'd10,
      PH_K_TIME       = 5'd11,
      PH_K_VALUE      = 5'd12,
      PH_K_PREVAL     = 5'd13,
      PH_K_PREW       = 5'd14,
      PH_K_POSTW      = 5'd15,
      PH_K_PRESLOPE   = 5'd16,
      PH_K_POSTSLOPE  = 5'd17,
      PH_DONE         = 5'd18,
      PH_HALT         = 5'd19
   } phase_type;

   localparam logic [2:0] ST_FIELD  = 3'd0;
   localparam logic [2:0] ST_DONE   = 3'd1;
   localparam logic [2:0] ST_TRUNC  = 3'd2;
   localparam logic [2:0] ST_BADVER = 3'd3;
   localparam logic [2:0] ST_TRAIL  = 3'd4;

   localparam logic CSR_SLOPED_MODE = 1'b0;
   localparam logic CSR_HERMITE     = 1'b1;

   localparam logic [3:0] VERSION_OK   = 4'd1;
   localparam logic [1:0] VTYPE_FOUR   = 2'd2;
   localparam logic [1:0] VTYPE_TWO    = 2'd3;
   localparam logic [3:0] VSIZE_EIGHT  = 4'd8;
   localparam logic [3:0] VSIZE_FOUR   = 4'd4;
   localparam logic [3:0] VSIZE_TWO    = 4'd2;
   localparam logic [2:0] SLOPED_RESET = 3'd3;
   localparam logic       HERMITE_RESET = 1'b1;

   typedef struct packed {
      logic [4:0]  field_code;
      logic [63:0] field_value;
      logic [3:0]  field_bytes;
      logic [31:0] knot_index;
      logic [2:0]  status;
   } result_type;

   typedef struct packed {
      result_type  first;
      logic        has_second;
      logic [2:0]  second_status;
      logic [31:0] second_knot;
   } entry_type;

   function automatic logic [3:0] field_size(phase_type p, logic [3:0] value_size);
      logic [3:0] s;
      case (p)
         PH_HDR1, PH_HDR2, PH_K_FLAG: s = 4'd1;
         PH_PRE_LOOPS, PH_POST_LOOPS, PH_COUNT: s = 4'd4;
         PH_K_VALUE, PH_K_PREVAL, PH_K_PRESLOPE, PH_K_POSTSLOPE: s = value_size;
         default: s = 4'd8;
      endcase
      return s;
   endfunction

endpackage

// ===== hw/rtl/srp_front.sv =====
// Front end of the spline record parser: accepts blob bytes, walks the layout
// and builds one queue entry per byte that yields results. Depends on srp_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_blob,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [2:0]         csr_wdata,
   output logic               q_push,
   output srp_pkg::entry_type q_entry,
   input  logic               q_full
);

   srp_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  byte_count_ff, byte_count_in;
   logic [63:0] assembly_ff, assembly_in;
   logic [3:0]  value_size_ff, value_size_in;
   logic        hermite_ff, hermite_in;
   logic        pre_ff, pre_in;
   logic        post_ff, post_in;
   logic        loop_ff, loop_in;
   logic        dual_ff, dual_in;
   logic [31:0] knots_left_ff, knots_left_in;
   logic [31:0] knot_counter_ff, knot_counter_in;
   logic        trail_ff, trail_in;
   logic [2:0]  sloped_code_ff;
   logic        hermite_code_ff;

   logic                 accept;
   logic [63:0]          asm_ins;
   logic [3:0]           size;
   logic                 complete;
   logic                 fld_valid;
   srp_pkg::result_type  fld;
   logic                 st_valid;
   logic [2:0]           st_code;
   logic [31:0]          st_knot;
   logic                 pre_new, post_new, loop_new;

   assign req_ready = !q_full;
   assign accept    = req_valid & req_ready;
   assign size      = srp_pkg::field_size(phase_ff, value_size_ff);
   assign complete  = ({1'b0, byte_count_ff} + 4'd1) >= size;
   assign pre_new   = pre_ff | (req_data_byte[2:0] == sloped_code_ff);
   assign post_new  = post_ff | (req_data_byte[5:3] == sloped_code_ff);
   assign loop_new  = loop_ff | req_data_byte[6];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         asm_ins[8*i +: 8] = (byte_count_ff == 3'(i)) ? req_data_byte : assembly_ff[8*i +: 8];
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      assembly_in     = assembly_ff;
      value_size_in   = value_size_ff;
      hermite_in      = hermite_ff;
      pre_in          = pre_ff;
      post_in         = post_ff;
      loop_in         = loop_ff;
      dual_in         = dual_ff;
      knots_left_in   = knots_left_ff;
      knot_counter_in = knot_counter_ff;
      trail_in        = trail_ff;
      fld_valid       = 1'b0;
      fld             = '0;
      st_valid        = 1'b0;
      st_code         = srp_pkg::ST_DONE;
      st_knot         = '0;
      if (accept) begin
         if (phase_ff == srp_pkg::PH_DONE) begin
            trail_in = 1'b1;
         end else if (phase_ff == srp_pkg::PH_HDR1 &&
                      req_data_byte[3:0] != srp_pkg::VERSION_OK) begin
            fld_valid         = 1'b1;
            fld.field_code    = 5'(srp_pkg::PH_HDR1);
            fld.field_value   = {56'd0, req_data_byte};
            fld.field_bytes   = 4'd1;
            fld.knot_index    = '0;
            fld.status        = srp_pkg::ST_BADVER;
            phase_in          = srp_pkg::PH_HALT;
         end else if (phase_ff != srp_pkg::PH_HALT) begin
            if (complete) begin
               fld_valid       = 1'b1;
               fld.field_code  = 5'(phase_ff);
               fld.field_value = asm_ins;
               fld.field_bytes = size;
               fld.knot_index  = (phase_ff >= srp_pkg::PH_K_FLAG) ? knot_counter_ff : 32'd0;
               fld.status      = srp_pkg::ST_FIELD;
               assembly_in     = '0;
               byte_count_in   = '0;
               case (phase_ff)
                  srp_pkg::PH_HDR1: begin
                     case (req_data_byte[5:4])
                        srp_pkg::VTYPE_FOUR: value_size_in = srp_pkg::VSIZE_FOUR;
                        srp_pkg::VTYPE_TWO:  value_size_in = srp_pkg::VSIZE_TWO;
                        default:             value_size_in = srp_pkg::VSIZE_EIGHT;
                     endcase
                     hermite_in = hermite_ff | (req_data_byte[7] == hermite_code_ff);
                     phase_in   = srp_pkg::PH_HDR2;
                  end
                  srp_pkg::PH_HDR2: begin
                     pre_in  = pre_new;
                     post_in = post_new;
                     loop_in = loop_new;
                     phase_in = pre_new  ? srp_pkg::PH_PRE_SLOPE :
                                post_new ? srp_pkg::PH_POST_SLOPE :
                                loop_new ? srp_pkg::PH_PROTO_START : srp_pkg::PH_COUNT;
                  end
                  srp_pkg::PH_PRE_SLOPE: begin
                     phase_in = post_ff ? srp_pkg::PH_POST_SLOPE :
                                loop_ff ? srp_pkg::PH_PROTO_START : srp_pkg::PH_COUNT;
                  end
                  srp_pkg::PH_POST_SLOPE: begin
                     phase_in = loop_ff ? srp_pkg::PH_PROTO_START : srp_pkg::PH_COUNT;
                  end
                  srp_pkg::PH_PROTO_START: phase_in = srp_pkg::PH_PROTO_END;
                  srp_pkg::PH_PROTO_END:   phase_in = srp_pkg::PH_PRE_LOOPS;
                  srp_pkg::PH_PRE_LOOPS:   phase_in = srp_pkg::PH_POST_LOOPS;
                  srp_pkg::PH_POST_LOOPS:  phase_in = srp_pkg::PH_VALUE_OFFSET;
                  srp_pkg::PH_VALUE_OFFSET: phase_in = srp_pkg::PH_COUNT;
                  srp_pkg::PH_COUNT: begin
                     knots_left_in = asm_ins[31:0];
                     phase_in = (asm_ins[31:0] != 32'd0) ? srp_pkg::PH_K_FLAG : srp_pkg::PH_DONE;
                  end
                  srp_pkg::PH_K_FLAG: begin
                     dual_in  = req_data_byte[0];
                     phase_in = srp_pkg::PH_K_TIME;
                  end
                  srp_pkg::PH_K_TIME: phase_in = srp_pkg::PH_K_VALUE;
                  srp_pkg::PH_K_VALUE: begin
                     phase_in = dual_ff     ? srp_pkg::PH_K_PREVAL :
                                !hermite_ff ? srp_pkg::PH_K_PREW : srp_pkg::PH_K_PRESLOPE;
                  end
                  srp_pkg::PH_K_PREVAL: begin
                     phase_in = !hermite_ff ? srp_pkg::PH_K_PREW : srp_pkg::PH_K_PRESLOPE;
                  end
                  srp_pkg::PH_K_PREW:     phase_in = srp_pkg::PH_K_POSTW;
                  srp_pkg::PH_K_POSTW:    phase_in = srp_pkg::PH_K_PRESLOPE;
                  srp_pkg::PH_K_PRESLOPE: phase_in = srp_pkg::PH_K_POSTSLOPE;
                  srp_pkg::PH_K_POSTSLOPE: begin
                     knot_counter_in = knot_counter_ff + 32'd1;
                     knots_left_in   = knots_left_ff - 32'd1;
                     phase_in = (knots_left_ff != 32'd1) ? srp_pkg::PH_K_FLAG : srp_pkg::PH_DONE;
                  end
                  default: phase_in = phase_ff;
               endcase
            end else begin
               byte_count_in = byte_count_ff + 3'd1;
               assembly_in   = asm_ins;
            end
         end
         if (req_end_of_blob) begin
            if (phase_in == srp_pkg::PH_DONE) begin
               st_valid = 1'b1;
               st_code  = trail_in ? srp_pkg::ST_TRAIL : srp_pkg::ST_DONE;
            end else if (phase_in != srp_pkg::PH_HALT) begin
               st_valid = 1'b1;
               st_code  = srp_pkg::ST_TRUNC;
            end
            st_knot         = knot_counter_in;
            phase_in        = srp_pkg::PH_HDR1;
            byte_count_in   = '0;
            assembly_in     = '0;
            value_size_in   = srp_pkg::VSIZE_EIGHT;
            hermite_in      = 1'b0;
            pre_in          = 1'b0;
            post_in         = 1'b0;
            loop_in         = 1'b0;
            dual_in         = 1'b0;
            knots_left_in   = '0;
            knot_counter_in = '0;
            trail_in        = 1'b0;
         end
      end
   end

   always_comb begin
      q_push = fld_valid | st_valid;
      if (fld_valid) begin
         q_entry.first = fld;
      end else begin
         q_entry.first.field_code  = '0;
         q_entry.first.field_value = '0;
         q_entry.first.field_bytes = '0;
         q_entry.first.knot_index  = st_knot;
         q_entry.first.status      = st_code;
      end
      q_entry.has_second    = fld_valid & st_valid;
      q_entry.second_status = st_code;
      q_entry.second_knot   = st_knot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= srp_pkg::PH_HDR1;
         byte_count_ff   <= '0;
         assembly_ff     <= '0;
         value_size_ff   <= srp_pkg::VSIZE_EIGHT;
         hermite_ff      <= 1'b0;
         pre_ff          <= 1'b0;
         post_ff         <= 1'b0;
         loop_ff         <= 1'b0;
         dual_ff         <= 1'b0;
         knots_left_ff   <= '0;
         knot_counter_ff <= '0;
         trail_ff        <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         assembly_ff     <= assembly_in;
         value_size_ff   <= value_size_in;
         hermite_ff      <= hermite_in;
         pre_ff          <= pre_in;
         post_ff         <= post_in;
         loop_ff         <= loop_in;
         dual_ff         <= dual_in;
         knots_left_ff   <= knots_left_in;
         knot_counter_ff <= knot_counter_in;
         trail_ff        <= trail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sloped_code_ff  <= srp_pkg::SLOPED_RESET;
         hermite_code_ff <= srp_pkg::HERMITE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            srp_pkg::CSR_SLOPED_MODE: sloped_code_ff  <= csr_wdata;
            srp_pkg::CSR_HERMITE:     hermite_code_ff <= csr_wdata[0];
            default:                  sloped_code_ff  <= sloped_code_ff;
         endcase
      end
   end

   `SRP_ASSERT(a_halt_clean, clock, reset,
      phase_ff == srp_pkg::PH_HALT |-> byte_count_ff == 3'd0 && assembly_ff == 64'd0,
      "halted parser holds a partial field")
   `SRP_ASSERT(a_no_push_full, clock, reset, !(q_push && q_full),
      "transaction pushed into a full queue")

endmodule

// ===== hw/rtl/srp_queue.sv =====
// Entry queue between the parser front end and the result back end.
// Depends on srp_pkg for the entry type.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srp_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  srp_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output srp_pkg::entry_type pop_entry,
   output logic               empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   srp_pkg::entry_type mem [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `SRP_ASSERT(a_no_underflow, clock, reset, !(pop && empty),
      "transaction popped from an empty queue")
   `SRP_ASSERT(a_count_bound, clock, reset, count_ff <= CntW'(DEPTH),
      "queue occupancy beyond depth")

endmodule

// ===== hw/rtl/srp_back.sv =====
// Back end of the spline record parser: drains queue entries into the
// registered result channel, one or two results each. Depends on srp_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  srp_pkg::entry_type q_entry,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_field_code,
   output logic [63:0]        rsp_field_value,
   output logic [3:0]         rsp_field_bytes,
   output logic [31:0]        rsp_knot_index,
   output logic [2:0]         rsp_status,
   output logic               rsp_last_of_run
);

   logic                rsp_valid_ff, rsp_valid_in;
   srp_pkg::result_type res_ff, res_in;
   logic                last_ff, last_in;
   logic                pend_ff, pend_in;
   logic [2:0]          pend_status_ff, pend_status_in;
   logic [31:0]         pend_knot_ff, pend_knot_in;
   logic                load;

   assign load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      res_in         = res_ff;
      last_in        = last_ff;
      pend_in        = pend_ff;
      pend_status_in = pend_status_ff;
      pend_knot_in   = pend_knot_ff;
      q_pop          = 1'b0;
      if (load) begin
         if (pend_ff) begin
            rsp_valid_in       = 1'b1;
            res_in.field_code  = '0;
            res_in.field_value = '0;
            res_in.field_bytes = '0;
            res_in.knot_index  = pend_knot_ff;
            res_in.status      = pend_status_ff;
            last_in            = 1'b1;
            pend_in            = 1'b0;
         end else if (!q_empty) begin
            q_pop          = 1'b1;
            rsp_valid_in   = 1'b1;
            res_in         = q_entry.first;
            last_in        = !q_entry.has_second;
            pend_in        = q_entry.has_second;
            pend_status_in = q_entry.second_status;
            pend_knot_in   = q_entry.second_knot;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff         <= res_in;
      last_ff        <= last_in;
      pend_status_ff <= pend_status_in;
      pend_knot_ff   <= pend_knot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_code  = res_ff.field_code;
   assign rsp_field_value = res_ff.field_value;
   assign rsp_field_bytes = res_ff.field_bytes;
   assign rsp_knot_index  = res_ff.knot_index;
   assign rsp_status      = res_ff.status;
   assign rsp_last_of_run = last_ff;

   `SRP_ASSERT(a_pend_shown, clock, reset, pend_ff |-> rsp_valid_ff,
      "second result pending without a first on the channel")
   `SRP_ASSERT(a_last_matches, clock, reset,
      rsp_valid_ff && !last_ff |-> pend_ff,
      "run not closed but nothing pending")

endmodule

// ===== hw/rtl/spline_record_parser.sv =====
// Spline record parser top level: front end, entry queue and back end.
// Depends on srp_pkg, srp_front, srp_queue and srp_back.
//
// Usage:
//   req_* carries one blob byte per transaction (req_data_byte, with
//   req_end_of_blob on the final byte). rsp_* carries results: one per
//   completed little-endian field (status 0), and a status result at the
//   end of a blob (done, truncated, trailing bytes); a bad version byte
//   gives one status-3 result and the rest of that blob is dropped.
//   rsp_last_of_run marks the last result caused by a byte (at most two).
//   csr_* writes the sloped extrapolation mode code (index 0) and the
//   hermite curve type bit (index 1); write only while the block is idle.
// Timing:
//   A byte is taken every cycle while the queue has room; its first result
//   passes through the queue and then the result register before it is
//   shown on rsp. The result register emits one result per cycle while
//   rsp_ready is high, so a byte giving two results needs a second output
//   transfer, absorbed by the QUEUE_DEPTH-entry queue.
// Reset and stall:
//   Reset returns the parser to header byte one and restores both CSRs.
//   A stalled rsp holds its result; the queue then fills and req_ready falls.
`timescale 1ns / 1ps

module spline_record_parser #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_blob,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_field_code,
   output logic [63:0] rsp_field_value,
   output logic [3:0]  rsp_field_bytes,
   output logic [31:0] rsp_knot_index,
   output logic [2:0]  rsp_status,
   output logic        rsp_last_of_run,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [2:0]  csr_wdata
);

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   srp_pkg::entry_type push_entry;
   srp_pkg::entry_type pop_entry;

   srp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_blob (req_end_of_blob),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_push          (q_push),
      .q_entry         (push_entry),
      .q_full          (q_full)
   );

   srp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   srp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_entry         (pop_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_field_code  (rsp_field_code),
      .rsp_field_value (rsp_field_value),
      .rsp_field_bytes (rsp_field_bytes),
      .rsp_knot_index  (rsp_knot_index),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for spline_record_parser: feeds byte streams of spline blobs,
// predicts every field and end-of-blob status, and compares each result in order.
// Depends on srp_pkg and the spline_record_parser RTL only.
`timescale 1ns / 1ps

module tb_top;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_STALL     = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int REPORT_CAP     = 40;

   typedef struct {
      logic [4:0]  code;
      logic [63:0] value;
      logic [3:0]  nbytes;
      logic [31:0] knot;
      logic [2:0]  status;
      logic        last;
   } field_record_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_end_of_blob = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_field_code;
   logic [63:0] rsp_field_value;
   logic [3:0]  rsp_field_bytes;
   logic [31:0] rsp_knot_index;
   logic [2:0]  rsp_status;
   logic        rsp_last_of_run;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [2:0]  csr_wdata = 3'd0;

   spline_record_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_blob (req_end_of_blob),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_field_code  (rsp_field_code),
      .rsp_field_value (rsp_field_value),
      .rsp_field_bytes (rsp_field_bytes),
      .rsp_knot_index  (rsp_knot_index),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // parser model state
   logic [2:0]          sloped_cfg;
   logic                hermite_cfg;
   srp_pkg::phase_type  ph;
   logic [2:0]          nbytes;
   logic [63:0]         accum;
   logic [3:0]          vsize;
   logic                lf_hermite, lf_pre, lf_post, lf_loop, lf_dual;
   logic [31:0]         knots_left;
   logic [31:0]         knot_num;
   logic                seen_trailing;

   field_record_type pending_fields[$];
   logic [7:0]       blob_bytes[$];

   int  bytes_sent = 0;
   int  blobs_sent = 0;
   int  results_checked = 0;
   int  mismatches = 0;
   int  settings_used = 1;
   int  stall_left = 0;
   int  quiet_cycles = 0;
   bit  long_stall_ask = 0;
   bit  calm = 0;
   bit  offering = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [3:0] field_width_bytes(srp_pkg::phase_type p);
      case (p)
         srp_pkg::PH_HDR1, srp_pkg::PH_HDR2, srp_pkg::PH_K_FLAG: return 4'd1;
         srp_pkg::PH_PRE_LOOPS, srp_pkg::PH_POST_LOOPS, srp_pkg::PH_COUNT: return 4'd4;
         srp_pkg::PH_K_VALUE, srp_pkg::PH_K_PREVAL, srp_pkg::PH_K_PRESLOPE,
         srp_pkg::PH_K_POSTSLOPE: return vsize;
         default: return 4'd8;
      endcase
   endfunction

   function automatic logic field_present(srp_pkg::phase_type p);
      case (p)
         srp_pkg::PH_PRE_SLOPE: return lf_pre;
         srp_pkg::PH_POST_SLOPE: return lf_post;
         srp_pkg::PH_PROTO_START, srp_pkg::PH_PROTO_END, srp_pkg::PH_PRE_LOOPS,
         srp_pkg::PH_POST_LOOPS, srp_pkg::PH_VALUE_OFFSET:
            return lf_loop;
         srp_pkg::PH_K_PREVAL: return lf_dual;
         srp_pkg::PH_K_PREW, srp_pkg::PH_K_POSTW: return !lf_hermite;
         default: return 1'b1;
      endcase
   endfunction

   function automatic srp_pkg::phase_type skip_absent(srp_pkg::phase_type p);
      srp_pkg::phase_type q;
      q = p;
      while (q < srp_pkg::PH_K_POSTSLOPE && !field_present(q))
         q = srp_pkg::phase_type'(q + 1);
      return q;
   endfunction

   task automatic restart_blob();
      ph = srp_pkg::PH_HDR1;
      nbytes = '0;
      accum = '0;
      vsize = srp_pkg::VSIZE_EIGHT;
      lf_hermite = 1'b0;
      lf_pre = 1'b0;
      lf_post = 1'b0;
      lf_loop = 1'b0;
      lf_dual = 1'b0;
      knots_left = '0;
      knot_num = '0;
      seen_trailing = 1'b0;
   endtask

   task automatic predict_fields(input logic [7:0] b, input logic eob);
      field_record_type outs[2];
      int n;
      int width;
      int i;
      n = 0;
      if (ph == srp_pkg::PH_HALT) begin
      end else if (ph == srp_pkg::PH_DONE) begin
         seen_trailing = 1'b1;
      end else if (ph == srp_pkg::PH_HDR1 && b[3:0] != srp_pkg::VERSION_OK) begin
         outs[n] = '{code: srp_pkg::PH_HDR1, value: 64'(b), nbytes: 4'd1, knot: 32'd0,
                     status: srp_pkg::ST_BADVER, last: 1'b0};
         n++;
         ph = srp_pkg::PH_HALT;
      end else begin
         width = int'(field_width_bytes(ph));
         accum = accum | (64'(b) << (8 * nbytes));
         if (int'(nbytes) + 1 >= width) begin
            outs[n] = '{code: ph, value: accum, nbytes: 4'(width),
                        knot: (ph >= srp_pkg::PH_K_FLAG) ? knot_num : 32'd0,
                        status: srp_pkg::ST_FIELD, last: 1'b0};
            n++;
            case (ph)
               srp_pkg::PH_HDR1: begin
                  vsize = (b[5:4] == srp_pkg::VTYPE_FOUR) ? srp_pkg::VSIZE_FOUR :
                          (b[5:4] == srp_pkg::VTYPE_TWO) ? srp_pkg::VSIZE_TWO :
                          srp_pkg::VSIZE_EIGHT;
                  if (b[7] == hermite_cfg) lf_hermite = 1'b1;
                  ph = srp_pkg::PH_HDR2;
               end
               srp_pkg::PH_HDR2: begin
                  if (b[2:0] == sloped_cfg) lf_pre = 1'b1;
                  if (b[5:3] == sloped_cfg) lf_post = 1'b1;
                  if (b[6]) lf_loop = 1'b1;
                  ph = skip_absent(srp_pkg::PH_PRE_SLOPE);
               end
               srp_pkg::PH_COUNT: begin
                  knots_left = accum[31:0];
                  ph = (knots_left != 0) ? srp_pkg::PH_K_FLAG : srp_pkg::PH_DONE;
               end
               srp_pkg::PH_K_FLAG: begin
                  lf_dual = b[0];
                  ph = skip_absent(srp_pkg::PH_K_TIME);
               end
               srp_pkg::PH_K_POSTSLOPE: begin
                  knot_num = knot_num + 32'd1;
                  knots_left = knots_left - 32'd1;
                  ph = (knots_left != 0) ? srp_pkg::PH_K_FLAG : srp_pkg::PH_DONE;
               end
               default: ph = skip_absent(srp_pkg::phase_type'(ph + 1));
            endcase
            accum = '0;
            nbytes = '0;
         end else begin
            nbytes = nbytes + 3'd1;
         end
      end
      if (eob) begin
         if (ph == srp_pkg::PH_DONE) begin
            outs[n] = '{code: 5'd0, value: 64'd0, nbytes: 4'd0, knot: knot_num,
                        status: seen_trailing ? srp_pkg::ST_TRAIL : srp_pkg::ST_DONE,
                        last: 1'b0};
            n++;
         end else if (ph != srp_pkg::PH_HALT) begin
            outs[n] = '{code: 5'd0, value: 64'd0, nbytes: 4'd0, knot: knot_num,
                        status: srp_pkg::ST_TRUNC, last: 1'b0};
            n++;
         end
         restart_blob();
      end
      if (n > 0) outs[n - 1].last = 1'b1;
      for (i = 0; i < n; i++) pending_fields = {pending_fields, outs[i]};
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= REPORT_CAP)
         $display("mismatch at result %0d: %s got %0h want %0h", results_checked, what,
                  got, want);
   endtask

   task automatic check_result();
      field_record_type want;
      if (pending_fields.size() == 0) begin
         report_mismatch("unexpected result, field_code", 64'(rsp_field_code), 64'd0);
      end else begin
         want = pending_fields.pop_front();
         if (rsp_field_code !== want.code)
            report_mismatch("field_code", 64'(rsp_field_code), 64'(want.code));
         if (rsp_field_value !== want.value)
            report_mismatch("field_value", rsp_field_value, want.value);
         if (rsp_field_bytes !== want.nbytes)
            report_mismatch("field_bytes", 64'(rsp_field_bytes), 64'(want.nbytes));
         if (rsp_knot_index !== want.knot)
            report_mismatch("knot_index", 64'(rsp_knot_index), 64'(want.knot));
         if (rsp_status !== want.status)
            report_mismatch("status", 64'(rsp_status), 64'(want.status));
         if (rsp_last_of_run !== want.last)
            report_mismatch("last_of_run", 64'(rsp_last_of_run), 64'(want.last));
         results_checked++;
      end
   endtask

   // result side: check each transaction, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_result();
      if (stall_left > 0) begin
         stall_left--;
      end else if (long_stall_ask) begin
         stall_left = LONG_STALL;
         long_stall_ask = 0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(1, 16);
      end
      rsp_ready <= (stall_left == 0);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eob);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 16);
      if (gap > 0) begin
         if (offering) begin
            req_valid <= 1'b0;
            offering = 0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      offering = 1;
      req_data_byte <= b;
      req_end_of_blob <= eob;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_fields(b, eob);
      bytes_sent++;
   endtask

   task automatic hold_input();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 0;
      end
   endtask

   task automatic wait_drained();
      hold_input();
      while (pending_fields.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [2:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == srp_pkg::CSR_SLOPED_MODE) sloped_cfg = data;
      else hermite_cfg = data[0];
   endtask

   task automatic apply_settings(input logic [2:0] sloped, input logic hermite);
      wait_drained();
      write_csr(srp_pkg::CSR_SLOPED_MODE, sloped);
      write_csr(srp_pkg::CSR_HERMITE, {2'($urandom), hermite});
      settings_used++;
   endtask

   task automatic send_blob();
      int i;
      for (i = 0; i < blob_bytes.size(); i++)
         send_byte(blob_bytes[i], i == blob_bytes.size() - 1);
      blobs_sent++;
   endtask

   task automatic append_byte(input logic [7:0] b);
      blob_bytes = {blob_bytes, b};
   endtask

   task automatic push_field_bytes(input int count);
      int fill;
      int i;
      fill = $urandom_range(0, 7);
      for (i = 0; i < count; i++)
         append_byte(fill == 0 ? 8'h00 : fill == 1 ? 8'hFF : 8'($urandom));
   endtask

   task automatic build_blob(input int max_knots, input bit huge_count);
      logic [7:0]  head1, head2, flag;
      logic [1:0]  vtype;
      logic [2:0]  pre_mode, post_mode;
      logic        loop_bit;
      logic        hermite_layout;
      logic [31:0] count;
      int          vbytes;
      int          knots_built;
      int          k;
      blob_bytes.delete();
      vtype = 2'($urandom);
      head1 = {1'($urandom), 1'($urandom), vtype, srp_pkg::VERSION_OK};
      vbytes = (vtype == srp_pkg::VTYPE_FOUR) ? 4 : (vtype == srp_pkg::VTYPE_TWO) ? 2 : 8;
      hermite_layout = (head1[7] == hermite_cfg);
      pre_mode = $urandom_range(0, 1) ? sloped_cfg : 3'($urandom);
      post_mode = $urandom_range(0, 1) ? sloped_cfg : 3'($urandom);
      loop_bit = ($urandom_range(0, 3) == 0);
      head2 = {1'($urandom), loop_bit, post_mode, pre_mode};
      append_byte(head1);
      append_byte(head2);
      if (pre_mode == sloped_cfg) push_field_bytes(8);
      if (post_mode == sloped_cfg) push_field_bytes(8);
      if (loop_bit) begin
         push_field_bytes(8);
         push_field_bytes(8);
         push_field_bytes(4);
         push_field_bytes(4);
         push_field_bytes(8);
      end
      if (huge_count)
         count = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
      else
         count = $urandom_range(0, max_knots);
      append_byte(count[7:0]);
      append_byte(count[15:8]);
      append_byte(count[23:16]);
      append_byte(count[31:24]);
      knots_built = huge_count ? 2 : int'(count);
      for (k = 0; k < knots_built; k++) begin
         flag = 8'($urandom);
         append_byte(flag);
         push_field_bytes(8);
         push_field_bytes(vbytes);
         if (flag[0]) push_field_bytes(vbytes);
         if (!hermite_layout) begin
            push_field_bytes(8);
            push_field_bytes(8);
         end
         push_field_bytes(vbytes);
         push_field_bytes(vbytes);
      end
   endtask

   // mostly well-formed blobs, with some truncated, trailing, bad-version and noise streams mixed in
   task automatic send_mixed_blob();
      int pick;
      int cut;
      int i;
      logic [3:0] nib;
      pick = $urandom_range(0, 99);
      build_blob(3, (pick >= 70 && pick < 80) && ($urandom_range(0, 2) == 0));
      if (pick >= 70 && pick < 80) begin
         cut = $urandom_range(1, blob_bytes.size());
         while (blob_bytes.size() > cut) void'(blob_bytes.pop_back());
      end else if (pick >= 80 && pick < 88) begin
         push_field_bytes($urandom_range(1, 6));
      end else if (pick >= 88 && pick < 94) begin
         nib = 4'($urandom);
         if (nib == srp_pkg::VERSION_OK) nib = ~nib;
         blob_bytes[0] = {blob_bytes[0][7:4], nib};
         if ($urandom_range(0, 3) == 0)
            while (blob_bytes.size() > 1) void'(blob_bytes.pop_back());
      end else if (pick >= 94) begin
         blob_bytes.delete();
         for (i = $urandom_range(1, 12); i > 0; i--) append_byte(8'($urandom));
      end
      send_blob();
   endtask

   task automatic test_directed_edges();
      blob_bytes = '{8'h01};
      send_blob();
      blob_bytes = '{8'h00, 8'hFF};
      send_blob();
      blob_bytes = '{8'hFE};
      send_blob();
      blob_bytes = '{8'hF1};
      send_blob();
      blob_bytes = '{8'h21, 8'hFF};
      send_blob();
      blob_bytes = '{8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_blob();
      blob_bytes = '{8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA, 8'h55};
      send_blob();
      wait_drained();
   endtask

   task automatic test_register_settings();
      logic [2:0] sloped_list[4];
      logic       hermite_list[4];
      int s;
      int goal;
      sloped_list = '{3'd0, 3'd7, 3'd7, 3'($urandom)};
      hermite_list = '{1'b0, 1'b1, 1'b0, 1'($urandom)};
      for (s = 0; s < 4; s++) begin
         apply_settings(sloped_list[s], hermite_list[s]);
         goal = bytes_sent + 130;
         while (bytes_sent < goal) send_mixed_blob();
      end
   endtask

   task automatic test_mixed_traffic();
      int goal;
      apply_settings(3'($urandom), 1'($urandom));
      goal = bytes_sent + 800;
      while (bytes_sent < goal) send_mixed_blob();
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      int goal;
      long_stall_ask = 1;
      goal = bytes_sent + 200;
      while (bytes_sent < goal) send_mixed_blob();
      wait_drained();
   endtask

   task automatic test_full_rate_tail();
      int goal;
      apply_settings(srp_pkg::SLOPED_RESET, srp_pkg::HERMITE_RESET);
      calm = 1;
      goal = bytes_sent + 300;
      while (bytes_sent < goal) send_mixed_blob();
      wait_drained();
   endtask

   initial begin
      sloped_cfg = srp_pkg::SLOPED_RESET;
      hermite_cfg = srp_pkg::HERMITE_RESET;
      restart_blob();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_register_settings();
      test_mixed_traffic();
      test_output_backpressure();
      test_full_rate_tail();
      $display("run covered %0d bytes in %0d blobs under %0d register settings",
               bytes_sent, blobs_sent, settings_used);
      $display("%0d results compared, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
